>>> sv/bae_pkg.sv
// ----------------------------------------------------------------------------
// bae_pkg - shared types and constants for the bytecode ALU execute core
// Opcode codes, request/response payload structs and register file sizing.
// ----------------------------------------------------------------------------
package bae_pkg;

	localparam int NUM_REGS = 16;

	localparam int OPC_W = 5;
	localparam int IDX_W = 4;
	localparam int IMM_W = 8;
	localparam int DATA_W = 32;

	typedef enum logic [OPC_W-1:0] {
		OPC_ADD   = 5'd0,
		OPC_SUB   = 5'd1,
		OPC_MUL   = 5'd2,
		OPC_OR    = 5'd3,
		OPC_XOR   = 5'd4,
		OPC_AND   = 5'd5,
		OPC_ANDN  = 5'd6,
		OPC_SHL   = 5'd7,
		OPC_SHR   = 5'd8,
		OPC_MOV   = 5'd9,
		OPC_EQ    = 5'd10,
		OPC_NEQ   = 5'd11,
		OPC_LT    = 5'd12,
		OPC_LTS   = 5'd13,
		OPC_LTEQ  = 5'd14,
		OPC_LTEQS = 5'd15,
		OPC_ADD8  = 5'd16,
		OPC_CST8  = 5'd17,
		OPC_BITC  = 5'd18,
		OPC_BITS  = 5'd19,
		OPC_TSTC  = 5'd20,
		OPC_TSTS  = 5'd21,
		OPC_SHIL  = 5'd22,
		OPC_SHIR  = 5'd23,
		OPC_EXTZ  = 5'd24,
		OPC_EXTS  = 5'd25
	} opcode_t;

	typedef struct packed {
		logic [OPC_W-1:0] opcode;
		logic [IDX_W-1:0] dest_index;
		logic [IDX_W-1:0] source_index;
		logic [IMM_W-1:0] immediate;
	} req_t;

	typedef struct packed {
		logic              skip_next;
		logic              written;
		logic [DATA_W-1:0] dest_value;
	} rsp_t;

endpackage

>>> sv/bae_alu.sv
// ----------------------------------------------------------------------------
// bae_alu - combinational execute datapath
// Computes result, write enable and skip flag from the two register operands and the immediate.
// ----------------------------------------------------------------------------
module bae_alu (
	input  logic [bae_pkg::OPC_W-1:0]  opcode,
	input  logic                       same,
	input  logic [bae_pkg::DATA_W-1:0] a,
	input  logic [bae_pkg::DATA_W-1:0] b,
	input  logic [bae_pkg::IMM_W-1:0]  immediate,
	output bae_pkg::rsp_t              rsp
);

	logic [4:0]                 pos;
	logic [bae_pkg::DATA_W-1:0] bitm;
	logic [bae_pkg::DATA_W-1:0] mask;
	logic [bae_pkg::DATA_W-1:0] sbit;
	logic [bae_pkg::DATA_W-1:0] prod;
	logic [bae_pkg::DATA_W-1:0] cmp_b;
	logic [4:0]                 msb_idx;
	logic                       b_big;
	logic [bae_pkg::DATA_W-1:0] r;
	logic                       wr;
	logic                       skip;

	assign pos   = immediate[4:0];
	assign bitm  = 32'd1 << pos;
	assign mask  = 32'hffff_ffff >> pos;
	assign sbit  = 32'h8000_0000 >> pos;
	assign prod  = a * b;
	assign cmp_b = same ? '0 : b;
	assign b_big = |b[31:5];

	// top set bit index; zero and one both give 0
	always_comb begin
		msb_idx = '0;
		for (int i = 1; i < bae_pkg::DATA_W; i++) begin
			if (b[i])
				msb_idx = 5'(i);
		end
	end

	always_comb begin
		r    = a;
		wr   = 1'b1;
		skip = 1'b0;
		case (opcode)
			bae_pkg::OPC_ADD:  r = a + b;
			bae_pkg::OPC_SUB:  r = (same ? '0 : a) - b;
			bae_pkg::OPC_MUL:  r = prod;
			bae_pkg::OPC_OR: begin
				if (same) wr = 1'b0;
				else r = a | b;
			end
			bae_pkg::OPC_XOR: begin
				if (same) wr = 1'b0;
				else r = a ^ b;
			end
			bae_pkg::OPC_AND:  r = a & b;
			bae_pkg::OPC_ANDN: r = same ? ~b : (~b & a);
			bae_pkg::OPC_SHL:  r = b_big ? '0 : (a << b[4:0]);
			bae_pkg::OPC_SHR:  r = b_big ? '0 : (a >> b[4:0]);
			bae_pkg::OPC_MOV:  r = same ? {27'd0, msb_idx} : b;
			bae_pkg::OPC_EQ: begin
				skip = (a != cmp_b);
				wr   = 1'b0;
			end
			bae_pkg::OPC_NEQ: begin
				skip = (a == cmp_b);
				wr   = 1'b0;
			end
			bae_pkg::OPC_LT: begin
				skip = !(a < b);
				wr   = 1'b0;
			end
			bae_pkg::OPC_LTEQ: begin
				skip = !(a <= b);
				wr   = 1'b0;
			end
			bae_pkg::OPC_LTS: begin
				skip = !($signed(a) < $signed(b));
				wr   = 1'b0;
			end
			bae_pkg::OPC_LTEQS: begin
				skip = !($signed(a) <= $signed(b));
				wr   = 1'b0;
			end
			bae_pkg::OPC_ADD8: begin
				if (immediate == '0) wr = 1'b0;
				else r = a + {{24{immediate[7]}}, immediate};
			end
			bae_pkg::OPC_CST8: r = {24'd0, immediate};
			bae_pkg::OPC_BITC: r = a & ~bitm;
			bae_pkg::OPC_BITS: r = a | bitm;
			bae_pkg::OPC_TSTC: begin
				skip = a[pos];
				wr   = 1'b0;
			end
			bae_pkg::OPC_TSTS: begin
				skip = !a[pos];
				wr   = 1'b0;
			end
			bae_pkg::OPC_SHIL: r = a << pos;
			bae_pkg::OPC_SHIR: r = a >> pos;
			bae_pkg::OPC_EXTZ: r = a & mask;
			bae_pkg::OPC_EXTS: r = ((a & mask) ^ sbit) - sbit;
			default:           wr = 1'b0;
		endcase
	end

	assign rsp.skip_next  = skip;
	assign rsp.written    = wr;
	assign rsp.dest_value = wr ? r : a;

endmodule

>>> sv/bytecode_alu_execute_core.sv
// ----------------------------------------------------------------------------
// bytecode_alu_execute_core - execute unit of a small bytecode machine
// Register file in a synchronous memory, one ALU stage, registered response.
// ----------------------------------------------------------------------------
// One instruction per cycle sustained while responses are accepted. An
// instruction's operands are read from the register file memory at the edge
// where it is transferred in. It executes in the following cycle, and when it
// leaves stage 1 the result is written back and the response is registered.
// A write that lands on the same edge as the next instruction's read is
// forwarded, so dependent instructions issue back to back. Registers read as
// zero after reset through per-register valid flags; no clearing pass is
// needed.
// ----------------------------------------------------------------------------
module bytecode_alu_execute_core #(
	parameter int NUM_REGS = bae_pkg::NUM_REGS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bae_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bae_pkg::rsp_t rsp
);

	localparam int AW = $clog2(NUM_REGS);

	logic [bae_pkg::DATA_W-1:0] rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0]        rf_vld_q;

	logic                       req_xfer;
	logic                       s1_adv;
	logic                       wb_en;

	// stage 1
	logic                       vld_s1;
	bae_pkg::req_t              req_s1;
	logic [bae_pkg::DATA_W-1:0] a_raw_s1;
	logic [bae_pkg::DATA_W-1:0] b_raw_s1;
	logic                       a_vld_s1;
	logic                       b_vld_s1;

	// last write back, for read-during-write
	logic                       fwd_en_q;
	logic [AW-1:0]              fwd_idx_q;
	logic [bae_pkg::DATA_W-1:0] fwd_data_q;

	logic [AW-1:0]              d_idx_s1;
	logic [AW-1:0]              s_idx_s1;
	logic [bae_pkg::DATA_W-1:0] a_op;
	logic [bae_pkg::DATA_W-1:0] b_op;
	bae_pkg::rsp_t              alu_rsp;

	logic                       rsp_vld_q;
	bae_pkg::rsp_t              rsp_q;

	assign s1_adv    = vld_s1 && (!rsp_vld_q || rsp_ready);
	assign req_ready = !vld_s1 || s1_adv;
	assign req_xfer  = req_valid && req_ready;

	assign d_idx_s1 = req_s1.dest_index[AW-1:0];
	assign s_idx_s1 = req_s1.source_index[AW-1:0];

	always_comb begin
		if (fwd_en_q && (fwd_idx_q == d_idx_s1))
			a_op = fwd_data_q;
		else
			a_op = a_vld_s1 ? a_raw_s1 : '0;
		if (fwd_en_q && (fwd_idx_q == s_idx_s1))
			b_op = fwd_data_q;
		else
			b_op = b_vld_s1 ? b_raw_s1 : '0;
	end

	bae_alu u_alu (
		.opcode    (req_s1.opcode),
		.same      (d_idx_s1 == s_idx_s1),
		.a         (a_op),
		.b         (b_op),
		.immediate (req_s1.immediate),
		.rsp       (alu_rsp)
	);

	assign wb_en = s1_adv && alu_rsp.written;

	// register file memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wb_en)
			rf_mem[d_idx_s1] <= alu_rsp.dest_value;
		if (req_xfer) begin
			a_raw_s1 <= rf_mem[req.dest_index[AW-1:0]];
			b_raw_s1 <= rf_mem[req.source_index[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			vld_s1   <= 1'b0;
			fwd_en_q <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (wb_en)
				rf_vld_q[d_idx_s1] <= 1'b1;
			if (req_xfer)
				vld_s1 <= 1'b1;
			else if (s1_adv)
				vld_s1 <= 1'b0;
			if (wb_en)
				fwd_en_q <= 1'b1;
			if (s1_adv)
				rsp_vld_q <= 1'b1;
			else if (rsp_ready)
				rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_s1   <= req;
			a_vld_s1 <= rf_vld_q[req.dest_index[AW-1:0]];
			b_vld_s1 <= rf_vld_q[req.source_index[AW-1:0]];
		end
		if (wb_en) begin
			fwd_idx_q  <= d_idx_s1;
			fwd_data_q <= alu_rsp.dest_value;
		end
		if (s1_adv)
			rsp_q <= alu_rsp;
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule
